### hw/rtl/bpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

  localparam int DIV_W = 64;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_ZERO    = 2'd2;

  localparam logic [1:0] REG_TEMP_CALIB = 2'd0;
  localparam logic [1:0] REG_PRESS_P1   = 2'd1;
  localparam logic [1:0] REG_PRESS_P2P5 = 2'd2;
  localparam logic [1:0] REG_PRESS_P6P9 = 2'd3;

  localparam logic [19:0] RAW_INVALID = 20'h80000;

  typedef struct packed {
    logic [7:0] press_msb;
    logic [7:0] press_lsb;
    logic [7:0] press_xlsb;
    logic [7:0] temp_msb;
    logic [7:0] temp_lsb;
    logic [7:0] temp_xlsb;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [23:0]        pressure;
    logic signed [15:0] temp_centi;
  } out_t;

  // flags and temperature that ride along with the pressure path
  typedef struct packed {
    logic               inv;
    logic               zero;
    logic signed [15:0] tc;
  } side_t;

endpackage
`default_nettype wire

### hw/rtl/bpc_div.sv
`timescale 1ns / 1ps
`default_nettype none
module bpc_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [bpc_pkg::DIV_W-1:0]    ua,
  input  logic [bpc_pkg::DIV_W-1:0]    ub,
  input  logic                         neg,
  input  bpc_pkg::side_t               in_side,
  output logic                         out_valid,
  output logic [bpc_pkg::DIV_W-1:0]    quot,
  output bpc_pkg::side_t               out_side
);
  import bpc_pkg::*;

  // one quotient bit per stage, dividend shifts out the top of aq while
  // quotient bits shift in at the bottom
  logic [DIV_W-1:0] rem_s [0:DIV_W];
  logic [DIV_W-1:0] aq_s  [0:DIV_W];
  logic [DIV_W-1:0] ub_s  [0:DIV_W];
  logic             neg_s [0:DIV_W];
  logic             vld_s [0:DIV_W];
  side_t            side_s [0:DIV_W];

  assign rem_s[0]  = '0;
  assign aq_s[0]   = ua;
  assign ub_s[0]   = ub;
  assign neg_s[0]  = neg;
  assign vld_s[0]  = in_valid;
  assign side_s[0] = in_side;

  for (genvar i = 0; i < DIV_W; i++) begin : g_stage
    logic [DIV_W:0] shifted;
    logic           ge;
    logic [DIV_W:0] diff;
    assign shifted = {rem_s[i], aq_s[i][DIV_W-1]};
    assign diff    = shifted - {1'b0, ub_s[i]};
    assign ge      = shifted >= {1'b0, ub_s[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[i+1] <= 1'b0;
      end else begin
        vld_s[i+1] <= vld_s[i];
      end
      rem_s[i+1]  <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      aq_s[i+1]   <= {aq_s[i][DIV_W-2:0], ge};
      ub_s[i+1]   <= ub_s[i];
      neg_s[i+1]  <= neg_s[i];
      side_s[i+1] <= side_s[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld_s[DIV_W];
    end
    quot     <= neg_s[DIV_W] ? (~aq_s[DIV_W] + 1'b1) : aq_s[DIV_W];
    out_side <= side_s[DIV_W];
  end

endmodule
`default_nettype wire

### hw/rtl/barometric_pressure_compensation_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   signals                      direction  notes
// sample    start, busy, in_word         in         taken when start and not busy
// result    done, result                 out        one-cycle strobe, no back-pressure
// calib     wr_en, wr_index, wr_data     in         plain register write
//
// one word per cycle, fully pipelined; the signed divider in the middle of the
// pipe is built of 64 one-bit stages
// busy stays low, there is no stall anywhere in the pipe
// rst clears the valid bits and the calibration registers to zero
module barometric_pressure_compensation_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  bpc_pkg::in_t   in_word,
  output logic           done,
  output bpc_pkg::out_t  result,
  input  logic           wr_en,
  input  logic [1:0]     wr_index,
  input  logic [63:0]    wr_data
);
  import bpc_pkg::*;

  logic [47:0] temp_calib;
  logic [15:0] press_p1;
  logic [63:0] press_p2_to_p5;
  logic [63:0] press_p6_to_p9;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib     <= '0;
      press_p1       <= '0;
      press_p2_to_p5 <= '0;
      press_p6_to_p9 <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TEMP_CALIB: temp_calib     <= wr_data[47:0];
        REG_PRESS_P1:   press_p1       <= wr_data[15:0];
        REG_PRESS_P2P5: press_p2_to_p5 <= wr_data;
        REG_PRESS_P6P9: press_p6_to_p9 <= wr_data;
        default:        temp_calib     <= temp_calib;
      endcase
    end
  end

  assign busy = 1'b0;

  logic [15:0] t1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = temp_calib[15:0];
  assign t2 = temp_calib[31:16];
  assign t3 = temp_calib[47:32];
  assign p2 = press_p2_to_p5[15:0];
  assign p3 = press_p2_to_p5[31:16];
  assign p4 = press_p2_to_p5[47:32];
  assign p5 = press_p2_to_p5[63:48];
  assign p6 = press_p6_to_p9[15:0];
  assign p7 = press_p6_to_p9[31:16];
  assign p8 = press_p6_to_p9[47:32];
  assign p9 = press_p6_to_p9[63:48];

  // stage 0: assemble readings
  logic        v0;
  logic [19:0] ap0, at0;
  logic        inv0;
  logic [19:0] ap_raw, at_raw;
  assign ap_raw = {in_word.press_msb, in_word.press_lsb, in_word.press_xlsb[7:4]};
  assign at_raw = {in_word.temp_msb, in_word.temp_lsb, in_word.temp_xlsb[7:4]};

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else     v0 <= start;
    ap0  <= ap_raw;
    at0  <= at_raw;
    inv0 <= (ap_raw == RAW_INVALID) || (at_raw == RAW_INVALID);
  end

  // stage 1: temperature products
  logic signed [17:0] e1;
  logic signed [16:0] d1;
  logic signed [33:0] vt1_next, dd_next;
  logic               v1s, inv1;
  logic [19:0]        ap1;
  logic signed [33:0] vt1, dd1;
  assign e1       = $signed({1'b0, at0[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign d1       = $signed({1'b0, at0[19:4]}) - $signed({1'b0, t1});
  assign vt1_next = e1 * t2;
  assign dd_next  = d1 * d1;

  always_ff @(posedge clk) begin
    if (rst) v1s <= 1'b0;
    else     v1s <= v0;
    inv1 <= inv0;
    ap1  <= ap0;
    vt1  <= vt1_next;
    dd1  <= dd_next;
  end

  // stage 2
  logic signed [21:0] dsh;
  logic signed [37:0] w2_next, w2;
  logic signed [22:0] va2;
  logic               v2s, inv2;
  logic [19:0]        ap2;
  assign dsh     = dd1[33:12];
  assign w2_next = dsh * t3;

  always_ff @(posedge clk) begin
    if (rst) v2s <= 1'b0;
    else     v2s <= v1s;
    inv2 <= inv1;
    ap2  <= ap1;
    va2  <= vt1[33:11];
    w2   <= w2_next;
  end

  // stage 3: fine temperature
  logic signed [24:0] tf3;
  logic               v3s, inv3;
  logic [19:0]        ap3;

  always_ff @(posedge clk) begin
    if (rst) v3s <= 1'b0;
    else     v3s <= v2s;
    inv3 <= inv2;
    ap3  <= ap2;
    tf3  <= {{2{va2[22]}}, va2} + {w2[37], w2[37:14]};
  end

  // stage 4: centidegrees with saturation, pressure offset
  logic [27:0]        tcw;
  logic signed [19:0] tc20;
  logic signed [15:0] tc_sat;
  logic signed [25:0] pv1_next, pv1;
  logic               v4s;
  logic [19:0]        ap4;
  side_t              sd4;
  assign tcw      = {{3{tf3[24]}}, tf3} + {tf3[24], tf3, 2'b0} + 28'd128;
  assign tc20     = tcw[27:8];
  assign pv1_next = {tf3[24], tf3} - 26'd128000;

  always_comb begin
    if (tc20 > 20'sd32767)       tc_sat = 16'sh7fff;
    else if (tc20 < -20'sd32768) tc_sat = -16'sh8000;
    else                         tc_sat = tc20[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) v4s <= 1'b0;
    else     v4s <= v3s;
    ap4      <= ap3;
    pv1      <= pv1_next;
    sd4.inv  <= inv3;
    sd4.zero <= 1'b0;
    sd4.tc   <= tc_sat;
  end

  // stage 5
  logic signed [51:0] sq5;
  logic signed [41:0] m5, m2;
  logic               v5s;
  logic [19:0]        ap5;
  side_t              sd5;

  always_ff @(posedge clk) begin
    if (rst) v5s <= 1'b0;
    else     v5s <= v4s;
    ap5 <= ap4;
    sd5 <= sd4;
    sq5 <= pv1 * pv1;
    m5  <= pv1 * p5;
    m2  <= pv1 * p2;
  end

  // stage 6
  logic signed [67:0] a_full, b_full;
  logic [63:0]        a6, b6;
  logic signed [41:0] m5_6, m2_6;
  logic               v6s;
  logic [19:0]        ap6;
  side_t              sd6;
  assign a_full = sq5 * p6;
  assign b_full = sq5 * p3;

  always_ff @(posedge clk) begin
    if (rst) v6s <= 1'b0;
    else     v6s <= v5s;
    ap6  <= ap5;
    sd6  <= sd5;
    a6   <= a_full[63:0];
    b6   <= b_full[63:0];
    m5_6 <= m5;
    m2_6 <= m2;
  end

  // stage 7: var1 and var2 of the pressure formula
  logic [63:0] v2_7, v1_7;
  logic        v7s;
  logic [19:0] ap7;
  side_t       sd7;

  always_ff @(posedge clk) begin
    if (rst) v7s <= 1'b0;
    else     v7s <= v6s;
    ap7  <= ap6;
    sd7  <= sd6;
    v2_7 <= a6 + ({{22{m5_6[41]}}, m5_6} << 17) + ({{48{p4[15]}}, p4} << 35);
    v1_7 <= {{8{b6[63]}}, b6[63:8]} + ({{22{m2_6[41]}}, m2_6} << 12);
  end

  // stage 8: divisor scale, dividend base
  logic [63:0] x8;
  logic [79:0] y_full;
  logic [20:0] pbase;
  logic [63:0] y8, num8;
  logic        v8s;
  side_t       sd8;
  assign x8     = 64'h0000_8000_0000_0000 + v1_7;
  assign y_full = {16'b0, x8} * {64'b0, press_p1};
  assign pbase  = 21'h100000 - {1'b0, ap7};

  always_ff @(posedge clk) begin
    if (rst) v8s <= 1'b0;
    else     v8s <= v7s;
    sd8  <= sd7;
    y8   <= y_full[63:0];
    num8 <= ({43'b0, pbase} << 31) - v2_7;
  end

  // stage 9
  logic [75:0] nf;
  logic [63:0] num9, den9;
  logic        v9s;
  side_t       sd9;
  assign nf = {12'b0, num8} * 76'd3125;

  always_ff @(posedge clk) begin
    if (rst) v9s <= 1'b0;
    else     v9s <= v8s;
    sd9.inv  <= sd8.inv;
    sd9.zero <= (y8[63:33] == 31'd0);
    sd9.tc   <= sd8.tc;
    num9     <= nf[63:0];
    den9     <= {{33{y8[63]}}, y8[63:33]};
  end

  // stage 10: magnitudes for the divider
  logic [63:0] ua10, ub10;
  logic        neg10, v10s;
  side_t       sd10;

  always_ff @(posedge clk) begin
    if (rst) v10s <= 1'b0;
    else     v10s <= v9s;
    sd10  <= sd9;
    ua10  <= num9[63] ? (~num9 + 1'b1) : num9;
    ub10  <= den9[63] ? (~den9 + 1'b1) : den9;
    neg10 <= num9[63] ^ den9[63];
  end

  logic [63:0] pq;
  logic        vq;
  side_t       sdq;

  bpc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v10s),
    .ua        (ua10),
    .ub        (ub10),
    .neg       (neg10),
    .in_side   (sd10),
    .out_valid (vq),
    .quot      (pq),
    .out_side  (sdq)
  );

  // post stage a
  logic signed [50:0] s_a;
  logic signed [66:0] m_full;
  logic signed [79:0] vb_full;
  logic [63:0]        ma, pa_p, vb_a;
  logic signed [50:0] sa;
  logic               vas;
  side_t              sda;
  assign s_a     = pq[63:13];
  assign m_full  = p9 * s_a;
  assign vb_full = p8 * $signed(pq);

  always_ff @(posedge clk) begin
    if (rst) vas <= 1'b0;
    else     vas <= vq;
    sda  <= sdq;
    ma   <= m_full[63:0];
    sa   <= s_a;
    pa_p <= pq;
    vb_a <= {{19{vb_full[63]}}, vb_full[63:19]};
  end

  // post stage b: low 64 bits of the 64x64 product in halves
  logic [63:0] sx;
  logic [63:0] pl_b, p_b, vb_b;
  logic [31:0] c1_b, c2_b;
  logic        vbs;
  side_t       sdb;
  assign sx = {{13{sa[50]}}, sa};

  always_ff @(posedge clk) begin
    if (rst) vbs <= 1'b0;
    else     vbs <= vas;
    sdb  <= sda;
    pl_b <= {32'b0, ma[31:0]} * {32'b0, sx[31:0]};
    c1_b <= ma[31:0] * sx[63:32];
    c2_b <= ma[63:32] * sx[31:0];
    p_b  <= pa_p;
    vb_b <= vb_a;
  end

  // post stage c
  logic [63:0] prod_c, va_c, p_c, vb_c;
  logic        vcs;
  side_t       sdc;
  assign prod_c = pl_b + {c1_b + c2_b, 32'b0};

  always_ff @(posedge clk) begin
    if (rst) vcs <= 1'b0;
    else     vcs <= vbs;
    sdc  <= sdb;
    va_c <= {{25{prod_c[63]}}, prod_c[63:25]};
    p_c  <= p_b;
    vb_c <= vb_b;
  end

  // post stage d: Q24.8 word
  logic [63:0] sum_d, q_d;
  logic [31:0] q32;
  logic        vds;
  side_t       sdd;
  assign sum_d = p_c + va_c + vb_c;
  assign q_d   = {{8{sum_d[63]}}, sum_d[63:8]} + {{44{p7[15]}}, p7, 4'b0};

  always_ff @(posedge clk) begin
    if (rst) vds <= 1'b0;
    else     vds <= vcs;
    sdd <= sdc;
    q32 <= q_d[31:0];
  end

  // output: rounding and status
  logic [32:0] rnd;
  logic [23:0] pa_sat;
  out_t        res_next;
  assign rnd    = {1'b0, q32} + 33'd128;
  assign pa_sat = rnd[32] ? 24'hffffff : rnd[31:8];

  always_comb begin
    res_next.status     = STATUS_OK;
    res_next.pressure   = pa_sat;
    res_next.temp_centi = sdd.tc;
    if (sdd.inv) begin
      res_next.status     = STATUS_INVALID;
      res_next.pressure   = '0;
      res_next.temp_centi = '0;
    end else if (sdd.zero || (q32 == 32'd0)) begin
      res_next.status   = STATUS_ZERO;
      res_next.pressure = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vds;
    result <= res_next;
  end

endmodule
`default_nettype wire

### hw/rtl/bpc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module bpc_checker (
  input logic          clk,
  input logic          rst,
  input logic          busy,
  input logic          done,
  input bpc_pkg::out_t result
);
  import bpc_pkg::*;

  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_done_after_rst: assert property (@(posedge clk) rst |=> !done)
    else $error("result right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == STATUS_OK || result.status == STATUS_INVALID ||
              result.status == STATUS_ZERO))
    else $error("bad status code");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == STATUS_INVALID) |->
      (result.pressure == 24'd0 && result.temp_centi == 16'sd0))
    else $error("invalid word carries data");

  a_fail_zero_pa: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == STATUS_ZERO) |-> (result.pressure == 24'd0))
    else $error("failed word carries pressure");

endmodule

bind barometric_pressure_compensation_unit bpc_checker u_bpc_checker (
  .clk    (clk),
  .rst    (rst),
  .busy   (busy),
  .done   (done),
  .result (result)
);
`default_nettype wire
